// ===== hdl/bpcs_pkg.sv =====
// types and constants shared by the bar pattern click sequencer
// no dependencies; compiled ahead of every other file in hdl

package bpcs_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_TOGGLE    = 2'd1,
    OP_LOAD_NOTE = 2'd2,
    OP_LOAD_BAR  = 2'd3
  } op_e;

  // result event codes
  typedef enum logic [1:0] {
    EV_CLICK   = 2'd0,
    EV_ACCENT  = 2'd1,
    EV_PATTERN = 2'd2,
    EV_RUN     = 2'd3
  } evt_e;

  // item sequencing phase
  typedef enum logic {
    PH_ACCEPT = 1'b0,
    PH_EXEC   = 1'b1
  } phase_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAT_INTERVAL = 2'd1;

  // field widths
  localparam int unsigned COUNT_W      = 6;
  localparam int unsigned BAR_COUNT_W  = 7;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned OUT_BAR_W    = 6;
  localparam int unsigned OUT_NOTE_W   = 5;
  localparam int unsigned BEAT_POS_W   = 5;
  localparam logic [COUNT_W-1:0] MAX_BEATS = 6'd32;

  // result queue
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = 2;
  localparam int unsigned RQ_CNT_W = 3;

  // one entry of the bar shape memory
  typedef struct packed {
    logic [COUNT_W-1:0] notes;
    logic [COUNT_W-1:0] beats;
  } shape_t;

  // one result beat
  typedef struct packed {
    evt_e                  kind;
    logic [OUT_BAR_W-1:0]  bar;
    logic [OUT_NOTE_W-1:0] note;
    logic                  running;
    logic                  last;
  } result_t;

endpackage

// ===== hdl/bar_pattern_click_sequencer_unit.sv =====
// bar pattern click sequencer: top level with tables, countdowns and result queue
// depends on bpcs_pkg
//
// Usage
// - input channel (in_valid_i / in_ready_o) carries one item per beat: a 1 ms
//   tick, a start/stop toggle, a note interval load or a bar shape load
// - result channel (out_valid_o / out_ready_i) carries events: click, accented
//   click, pattern click and running changed; last_o marks an item's final event
// - config channel (cfg_valid_i / cfg_ready_o) writes bar count and beat
//   interval; it is always ready; the user must write it only while the block is
//   idle, which the block does not enforce itself
// - an item is accepted, then executed: the bar shape memory is read at the accept
//   edge, execute updates positions and issues the note interval read, whose data
//   reloads the note countdown in the next accept cycle; no item is taken in execute
// - results go to a 4-entry queue; input is held off while fewer than two
//   slots are free, so a stalled receiver backs up into the input channel
// - reset clears positions, countdowns and the queue and stops counting; the
//   interval and shape tables are not cleared and must be loaded before start

module bar_pattern_click_sequencer_unit #(
  parameter int unsigned MAX_BARS      = 64,
  parameter int unsigned MAX_NOTES     = 32,
  parameter int unsigned INTERVAL_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          operation_i,
  input  logic [5:0]                          bar_index_i,
  input  logic [4:0]                          note_index_i,
  input  logic [15:0]                         interval_ms_i,
  input  logic [5:0]                          notes_in_bar_i,
  input  logic [5:0]                          beats_in_bar_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          event_kind_o,
  output logic [5:0]                          bar_position_o,
  output logic [4:0]                          note_position_o,
  output logic                                running_o,
  output logic                                last_o,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bpcs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bpcs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned BAR_AW = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int unsigned NOTE_AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int unsigned INT_DEPTH = MAX_BARS * MAX_NOTES;
  localparam int unsigned INT_AW = (INT_DEPTH > 1) ? $clog2(INT_DEPTH) : 1;
  localparam int unsigned IW = INTERVAL_BITS;

  // configuration registers
  logic [bpcs_pkg::BAR_COUNT_W-1:0] bar_count_q;
  logic [bpcs_pkg::CFG_DATA_W-1:0]  beat_int_q;

  // sequencing state
  bpcs_pkg::phase_e phase_q, phase_d;
  bpcs_pkg::op_e    op_q;
  logic             in_fire;

  // sequencer registers
  logic [BAR_AW-1:0]               bar_pos_q, bar_pos_d;
  logic [NOTE_AW-1:0]              note_pos_q, note_pos_d;
  logic [bpcs_pkg::BEAT_POS_W-1:0] beat_pos_q, beat_pos_d;
  logic [IW-1:0]                   note_cd_q, note_cd_d;
  logic [IW-1:0]                   beat_cd_q, beat_cd_d;
  logic                            run_q, run_d;
  logic                            reload_pend_q;

  // memories
  bpcs_pkg::shape_t  shape_mem [MAX_BARS];
  logic [IW-1:0]     int_mem [INT_DEPTH];
  bpcs_pkg::shape_t  shape_rd_q;
  logic [IW-1:0]     int_rd_q;

  // result queue
  bpcs_pkg::result_t              rq_mem [bpcs_pkg::RQ_DEPTH];
  logic [bpcs_pkg::RQ_PTR_W-1:0]  rq_wr_q, rq_rd_q;
  logic [bpcs_pkg::RQ_CNT_W-1:0]  rq_cnt_q;
  logic                           rq_pop;

  // execute results
  bpcs_pkg::result_t res0, res1;
  logic [1:0]        res_n;
  logic              reload_req;
  logic [BAR_AW-1:0] rd_bar;
  logic [NOTE_AW-1:0] rd_note;
  logic [INT_AW-1:0] int_raddr, int_waddr;

  // derived values
  logic [bpcs_pkg::COUNT_W-1:0]     beats_c, notes_c;
  logic [bpcs_pkg::BAR_COUNT_W-1:0] bars_c;
  logic [IW-1:0] beat_raw, beat_load, note_load;
  logic beat_exp, note_exp, last_beat, note_at_end, bar_at_end;
  logic load_note_ok, load_bar_ok;

  // config writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_count_q <= 7'd1;
      beat_int_q  <= 16'd500;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bpcs_pkg::CFG_BAR_COUNT:     bar_count_q <= cfg_data_i[bpcs_pkg::BAR_COUNT_W-1:0];
        bpcs_pkg::CFG_BEAT_INTERVAL: beat_int_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // phase state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bpcs_pkg::PH_ACCEPT;
    end else begin
      phase_q <= phase_d;
    end
  end

  // phase next state and handshake
  always_comb begin
    phase_d    = phase_q;
    in_ready_o = 1'b0;
    unique case (phase_q)
      bpcs_pkg::PH_ACCEPT: begin
        in_ready_o = (rq_cnt_q <= bpcs_pkg::RQ_CNT_W'(bpcs_pkg::RQ_DEPTH - 2));
        if (in_valid_i && in_ready_o) phase_d = bpcs_pkg::PH_EXEC;
      end
      bpcs_pkg::PH_EXEC: phase_d = bpcs_pkg::PH_ACCEPT;
      default: phase_d = bpcs_pkg::PH_ACCEPT;
    endcase
  end

  assign in_fire = in_valid_i && in_ready_o;

  // latched operation
  always_ff @(posedge clk_i) begin
    if (in_fire) op_q <= bpcs_pkg::op_e'(operation_i);
  end

  // load range checks and addresses
  assign load_bar_ok  = (32'(bar_index_i) < MAX_BARS);
  assign load_note_ok = load_bar_ok && (32'(note_index_i) < MAX_NOTES);
  assign int_waddr = INT_AW'(INT_AW'(BAR_AW'(bar_index_i)) * INT_AW'(MAX_NOTES)
                     + INT_AW'(NOTE_AW'(note_index_i)));
  assign int_raddr = INT_AW'(INT_AW'(rd_bar) * INT_AW'(MAX_NOTES) + INT_AW'(rd_note));

  // bar shape memory: written by a shape load, read at every accept
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (bpcs_pkg::op_e'(operation_i) == bpcs_pkg::OP_LOAD_BAR && load_bar_ok) begin
        shape_mem[BAR_AW'(bar_index_i)] <= '{notes: notes_in_bar_i, beats: beats_in_bar_i};
      end
      shape_rd_q <= shape_mem[bar_pos_q];
    end
  end

  // note interval memory: written by an interval load, read on reload
  always_ff @(posedge clk_i) begin
    if (in_fire && bpcs_pkg::op_e'(operation_i) == bpcs_pkg::OP_LOAD_NOTE && load_note_ok) begin
      int_mem[int_waddr] <= IW'(interval_ms_i);
    end
    if (phase_q == bpcs_pkg::PH_EXEC && reload_req) begin
      int_rd_q <= int_mem[int_raddr];
    end
  end

  // counts with zero and oversize handling
  always_comb begin
    beats_c = shape_rd_q.beats;
    if (beats_c == '0) beats_c = 6'd1;
    else if (beats_c > bpcs_pkg::MAX_BEATS) beats_c = bpcs_pkg::MAX_BEATS;

    notes_c = shape_rd_q.notes;
    if (notes_c == '0) notes_c = 6'd1;
    else if (32'(notes_c) > MAX_NOTES) notes_c = bpcs_pkg::COUNT_W'(MAX_NOTES);

    bars_c = bar_count_q;
    if (bars_c == '0) bars_c = 7'd1;
    else if (32'(bars_c) > MAX_BARS) bars_c = bpcs_pkg::BAR_COUNT_W'(MAX_BARS);
  end

  // reload values, interval zero counts as one tick
  assign beat_raw  = IW'(beat_int_q);
  assign beat_load = (beat_raw == '0) ? IW'(1) : beat_raw;
  assign note_load = (int_rd_q == '0) ? IW'(1) : int_rd_q;

  assign beat_exp    = (beat_cd_q <= IW'(1));
  assign note_exp    = (note_cd_q <= IW'(1));
  assign last_beat   = (6'(beat_pos_q) == beats_c - 6'd1);
  assign note_at_end = (32'(note_pos_q) + 32'd1 >= 32'(notes_c));
  assign bar_at_end  = (32'(bar_pos_q) + 32'd1 >= 32'(bars_c));

  // execute: tick and toggle handling, plus pending note reload
  always_comb begin
    bar_pos_d  = bar_pos_q;
    note_pos_d = note_pos_q;
    beat_pos_d = beat_pos_q;
    note_cd_d  = note_cd_q;
    beat_cd_d  = beat_cd_q;
    run_d      = run_q;
    res_n      = 2'd0;
    res0       = '0;
    res1       = '0;
    reload_req = 1'b0;
    rd_bar     = bar_pos_q;
    rd_note    = note_pos_q;

    if (reload_pend_q) note_cd_d = note_load;

    if (phase_q == bpcs_pkg::PH_EXEC) begin
      case (op_q)
        bpcs_pkg::OP_TOGGLE: begin
          if (run_q) begin
            run_d = 1'b0;
          end else begin
            run_d      = 1'b1;
            beat_cd_d  = beat_load;
            reload_req = 1'b1;
          end
          res0  = '{kind: bpcs_pkg::EV_RUN, bar: 6'(bar_pos_q), note: 5'(note_pos_q),
                    running: run_d, last: 1'b1};
          res_n = 2'd1;
        end
        bpcs_pkg::OP_TICK: begin
          if (run_q) begin
            beat_cd_d = beat_exp ? beat_load : beat_cd_q - IW'(1);
            if (!note_exp) note_cd_d = note_cd_q - IW'(1);
            if (beat_exp && last_beat) begin
              // bar end: accented click, next bar, pattern click at its first note
              beat_pos_d = '0;
              bar_pos_d  = bar_at_end ? '0 : bar_pos_q + BAR_AW'(1);
              note_pos_d = '0;
              res0 = '{kind: bpcs_pkg::EV_ACCENT, bar: 6'(bar_pos_q), note: 5'(note_pos_q),
                       running: 1'b1, last: 1'b0};
              res1 = '{kind: bpcs_pkg::EV_PATTERN, bar: 6'(bar_pos_d), note: 5'(note_pos_d),
                       running: 1'b1, last: 1'b1};
              res_n      = 2'd2;
              reload_req = 1'b1;
              rd_bar     = bar_pos_d;
              rd_note    = note_pos_d;
            end else begin
              if (beat_exp) begin
                beat_pos_d = beat_pos_q + 5'd1;
                res0 = '{kind: bpcs_pkg::EV_CLICK, bar: 6'(bar_pos_q), note: 5'(note_pos_q),
                         running: 1'b1, last: !note_exp};
              end
              if (note_exp) begin
                note_pos_d = note_at_end ? '0 : note_pos_q + NOTE_AW'(1);
                reload_req = 1'b1;
                rd_note    = note_pos_d;
                if (beat_exp) begin
                  res1 = '{kind: bpcs_pkg::EV_PATTERN, bar: 6'(bar_pos_q),
                           note: 5'(note_pos_d), running: 1'b1, last: 1'b1};
                end else begin
                  res0 = '{kind: bpcs_pkg::EV_PATTERN, bar: 6'(bar_pos_q),
                           note: 5'(note_pos_d), running: 1'b1, last: 1'b1};
                end
              end
              res_n = 2'(beat_exp) + 2'(note_exp);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_pos_q     <= '0;
      note_pos_q    <= '0;
      beat_pos_q    <= '0;
      note_cd_q     <= '0;
      beat_cd_q     <= '0;
      run_q         <= 1'b0;
      reload_pend_q <= 1'b0;
    end else begin
      bar_pos_q     <= bar_pos_d;
      note_pos_q    <= note_pos_d;
      beat_pos_q    <= beat_pos_d;
      note_cd_q     <= note_cd_d;
      beat_cd_q     <= beat_cd_d;
      run_q         <= run_d;
      reload_pend_q <= (phase_q == bpcs_pkg::PH_EXEC) && reload_req;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (res_n != 2'd0) rq_mem[rq_wr_q] <= res0;
    if (res_n == 2'd2) rq_mem[rq_wr_q + 2'd1] <= res1;
  end

  // result queue pointers
  assign rq_pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      rq_wr_q  <= rq_wr_q + bpcs_pkg::RQ_PTR_W'(res_n);
      rq_rd_q  <= rq_rd_q + bpcs_pkg::RQ_PTR_W'(rq_pop);
      rq_cnt_q <= rq_cnt_q + bpcs_pkg::RQ_CNT_W'(res_n) - bpcs_pkg::RQ_CNT_W'(rq_pop);
    end
  end

  // result outputs
  assign out_valid_o     = (rq_cnt_q != '0);
  assign event_kind_o    = rq_mem[rq_rd_q].kind;
  assign bar_position_o  = rq_mem[rq_rd_q].bar;
  assign note_position_o = rq_mem[rq_rd_q].note;
  assign running_o       = rq_mem[rq_rd_q].running;
  assign last_o          = rq_mem[rq_rd_q].last;

  // queue never overfills
  a_rq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_cnt_q <= bpcs_pkg::RQ_CNT_W'(bpcs_pkg::RQ_DEPTH))
    else $error("result queue overflow");

  // an accepted item is executed in the following cycle
  a_exec_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> phase_q == bpcs_pkg::PH_EXEC)
    else $error("accepted item not executed");

  // a note reload only follows an execute cycle
  a_reload_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reload_pend_q |-> $past(phase_q) == bpcs_pkg::PH_EXEC)
    else $error("stray note reload");

  // loads, and ticks while stopped, give no result
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == bpcs_pkg::PH_EXEC && (op_q == bpcs_pkg::OP_LOAD_NOTE ||
     op_q == bpcs_pkg::OP_LOAD_BAR || (op_q == bpcs_pkg::OP_TICK && !run_q)))
    |-> res_n == 2'd0)
    else $error("unexpected result");

  // positions stay inside the tables
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bar_pos_q) < MAX_BARS && 32'(note_pos_q) < MAX_NOTES)
    else $error("position out of table range");

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the bar pattern click sequencer
// drives items and register writes, predicts every event and compares it on the result channel
// depends on bpcs_pkg and bar_pattern_click_sequencer_unit
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 300;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // block ports
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           operation_i = '0;
  logic [5:0]           bar_index_i = '0;
  logic [4:0]           note_index_i = '0;
  logic [15:0]          interval_ms_i = '0;
  logic [5:0]           notes_in_bar_i = '0;
  logic [5:0]           beats_in_bar_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           event_kind_o;
  logic [5:0]           bar_position_o;
  logic [4:0]           note_position_o;
  logic                 running_o;
  logic                 last_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [bpcs_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [bpcs_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  bar_pattern_click_sequencer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .bar_index_i     (bar_index_i),
    .note_index_i    (note_index_i),
    .interval_ms_i   (interval_ms_i),
    .notes_in_bar_i  (notes_in_bar_i),
    .beats_in_bar_i  (beats_in_bar_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_kind_o    (event_kind_o),
    .bar_position_o  (bar_position_o),
    .note_position_o (note_position_o),
    .running_o       (running_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // predicted sequencer state
  logic [15:0] ivl_tbl [2048];
  logic [5:0]  shape_notes [64];
  logic [5:0]  shape_beats [64];
  logic [5:0]  bar_pos;
  logic [4:0]  note_pos;
  logic [4:0]  beat_pos;
  logic [15:0] note_cd;
  logic [15:0] beat_cd;
  logic        run_st;
  logic [6:0]  bar_cnt;
  logic [15:0] beat_iv;

  // expected events, oldest first
  bpcs_pkg::result_t exp_events [$];

  int errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int kinds_seen [4] = '{0, 0, 0, 0};
  int cycles = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit hold_req = 1'b0;

  // countdown reload: zero interval counts as one tick
  function automatic logic [15:0] reload_val(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  // zero acts as one, oversized counts saturate
  function automatic int unsigned clamp_cnt(logic [6:0] v, int unsigned hi);
    if (v == 7'd0) return 1;
    return (v > hi) ? hi : int'(v);
  endfunction

  // bars whose whole interval row is loaded and that may take large note counts
  function automatic bit full_row(logic [5:0] b);
    return (b < 6'd4) || (b == 6'd63);
  endfunction

  function automatic logic [15:0] cur_interval();
    return reload_val(ivl_tbl[{bar_pos, note_pos}]);
  endfunction

  task automatic push_event(bpcs_pkg::evt_e kind);
    bpcs_pkg::result_t r;
    r.kind    = kind;
    r.bar     = bar_pos;
    r.note    = note_pos;
    r.running = run_st;
    r.last    = 1'b0;
    exp_events.push_back(r);
  endtask

  // advance the predicted sequencer by one accepted item
  task automatic predict_events(bpcs_pkg::op_e op, logic [5:0] bi, logic [4:0] ni,
                                logic [15:0] iv, logic [5:0] nb, logic [5:0] bb);
    bit beat_due, note_due;
    int unsigned beats, bars, notes, first;
    first = exp_events.size();
    case (op)
      bpcs_pkg::OP_LOAD_NOTE: begin
        ivl_tbl[{bi, ni}] = iv;
      end
      bpcs_pkg::OP_LOAD_BAR: begin
        shape_notes[bi] = nb;
        shape_beats[bi] = bb;
      end
      bpcs_pkg::OP_TOGGLE: begin
        if (run_st) begin
          run_st = 1'b0;
        end else begin
          note_cd = cur_interval();
          beat_cd = reload_val(beat_iv);
          run_st  = 1'b1;
        end
        push_event(bpcs_pkg::EV_RUN);
      end
      default: begin
        if (run_st) begin
          beat_due = (beat_cd <= 16'd1);
          note_due = (note_cd <= 16'd1);
          if (!beat_due) beat_cd--;
          if (!note_due) note_cd--;
          // beat first; a bar change swallows a note expiry on the same tick
          if (beat_due) begin
            beats = clamp_cnt({1'b0, shape_beats[bar_pos]}, 32);
            if (beat_pos == beats - 1) begin
              bars = clamp_cnt(bar_cnt, 64);
              push_event(bpcs_pkg::EV_ACCENT);
              beat_pos = '0;
              if (bar_pos >= bars - 1) bar_pos = '0;
              else bar_pos++;
              note_pos = '0;
              note_cd  = cur_interval();
              push_event(bpcs_pkg::EV_PATTERN);
              note_due = 1'b0;
            end else begin
              push_event(bpcs_pkg::EV_CLICK);
              beat_pos++;
            end
            beat_cd = reload_val(beat_iv);
          end
          if (note_due) begin
            notes = clamp_cnt({1'b0, shape_notes[bar_pos]}, 32);
            if (note_pos >= notes - 1) note_pos = '0;
            else note_pos++;
            push_event(bpcs_pkg::EV_PATTERN);
            note_cd = cur_interval();
          end
        end
      end
    endcase
    if (exp_events.size() > first) exp_events[$].last = 1'b1;
  endtask

  // one item beat; valid stays up after acceptance until the next call or a settle
  task automatic send_item(bpcs_pkg::op_e op, logic [5:0] bi, logic [4:0] ni,
                           logic [15:0] iv, logic [5:0] nb, logic [5:0] bb);
    int gap;
    gap = send_gaps ? $urandom_range(17, 0) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    bar_index_i    <= bi;
    note_index_i   <= ni;
    interval_ms_i  <= iv;
    notes_in_bar_i <= nb;
    beats_in_bar_i <= bb;
    do @(posedge clk_i); while (!in_ready_o);
    predict_events(op, bi, ni, iv, nb, bb);
    n_items++;
  endtask

  // item with random filler in the fields the operation ignores
  task automatic send_op(bpcs_pkg::op_e op);
    send_item(op, 6'($urandom), 5'($urandom), 16'($urandom), 6'($urandom), 6'($urandom));
  endtask

  // drop valid and wait until every expected event is in, plus the pipeline depth
  task automatic settle_idle();
    int waited;
    in_valid_i <= 1'b0;
    waited = 0;
    @(posedge clk_i);
    while (exp_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (exp_events.size() != 0) begin
      $error("%0d expected events never arrived", exp_events.size());
      errors++;
      exp_events.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(logic [bpcs_pkg::CFG_IDX_W-1:0] idx,
                           logic [bpcs_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == bpcs_pkg::CFG_BAR_COUNT) bar_cnt = data[6:0];
    else beat_iv = data;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [6:0] bars, logic [15:0] beat);
    settle_idle();
    // upper bits of the bar count write are don't-care
    write_reg(bpcs_pkg::CFG_BAR_COUNT, {9'($urandom), bars});
    write_reg(bpcs_pkg::CFG_BEAT_INTERVAL, beat);
  endtask

  // every bar gets a shape of one or two notes and its first two intervals;
  // full-row bars get all 32 intervals so they may later take any note count
  task automatic test_table_init();
    send_gaps = 1'b0;
    for (int b = 0; b < 64; b++) begin
      send_item(bpcs_pkg::OP_LOAD_BAR, 6'(b), 5'($urandom), 16'($urandom),
                6'($urandom_range(2, 1)), 6'($urandom_range(4, 1)));
      for (int k = 0; k < 32; k++) begin
        if (k < 2 || full_row(6'(b))) begin
          send_item(bpcs_pkg::OP_LOAD_NOTE, 6'(b), 5'(k), 16'($urandom_range(3, 0)),
                    6'($urandom), 6'($urandom));
        end
      end
    end
    send_gaps = 1'b1;
  endtask

  // field extremes, every operation, zero and oversized counts, stopped ticks
  task automatic test_directed();
    configure(7'd2, 16'd0);
    send_item(bpcs_pkg::OP_LOAD_BAR, 6'd0, 5'd0, 16'd0, 6'd0, 6'd2);
    send_item(bpcs_pkg::OP_LOAD_BAR, 6'd1, 5'd31, 16'hFFFF, 6'd63, 6'd63);
    send_item(bpcs_pkg::OP_LOAD_BAR, 6'd63, 5'd0, 16'd0, 6'd32, 6'd32);
    send_item(bpcs_pkg::OP_LOAD_NOTE, 6'd0, 5'd0, 16'd0, 6'd0, 6'd0);
    send_item(bpcs_pkg::OP_LOAD_NOTE, 6'd63, 5'd31, 16'hFFFF, 6'd63, 6'd63);
    send_item(bpcs_pkg::OP_LOAD_NOTE, 6'd1, 5'd0, 16'd2, 6'd0, 6'd0);
    send_op(bpcs_pkg::OP_TICK);
    send_op(bpcs_pkg::OP_TOGGLE);
    repeat (5) send_op(bpcs_pkg::OP_TICK);
    send_op(bpcs_pkg::OP_TOGGLE);
    send_op(bpcs_pkg::OP_TICK);
    send_op(bpcs_pkg::OP_TOGGLE);
    repeat (3) send_op(bpcs_pkg::OP_TICK);
    send_op(bpcs_pkg::OP_TOGGLE);
  endtask

  // mostly running ticks, with table rewrites and occasional start/stop
  task automatic random_item();
    int r;
    logic [5:0] bi;
    logic [15:0] iv;
    logic [5:0] nb, bb;
    r  = $urandom_range(99, 0);
    bi = $urandom_range(1, 0) ? 6'($urandom_range(3, 0)) : 6'($urandom);
    if (r < 3 || (!run_st && r < 30)) begin
      send_op(bpcs_pkg::OP_TOGGLE);
    end else if (r < 75) begin
      send_op(bpcs_pkg::OP_TICK);
    end else if (r < 90) begin
      iv = ($urandom_range(15, 0) == 0) ? 16'($urandom) : 16'($urandom_range(7, 0));
      send_item(bpcs_pkg::OP_LOAD_NOTE, bi, 5'($urandom), iv, 6'($urandom), 6'($urandom));
    end else begin
      // large note counts only where the whole interval row is loaded
      if (full_row(bi)) begin
        nb = ($urandom_range(3, 0) == 0) ? 6'($urandom) : 6'($urandom_range(5, 1));
      end else begin
        nb = 6'($urandom_range(2, 1));
      end
      bb = ($urandom_range(3, 0) == 0) ? 6'($urandom) : 6'($urandom_range(4, 1));
      send_item(bpcs_pkg::OP_LOAD_BAR, bi, 5'($urandom), 16'($urandom), nb, bb);
    end
  endtask

  // random phases over several register settings, extremes included
  task automatic test_random_phases();
    logic [6:0] bars;
    logic [15:0] beat;
    for (int ph = 0; ph < 7; ph++) begin
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
      case (ph)
        0: begin bars = 7'd64; beat = 16'd3; end
        1: begin bars = 7'd0; beat = 16'd1; send_gaps = 1'b0; recv_gaps = 1'b0; end
        2: begin bars = 7'd127; beat = 16'd0; end
        3: begin bars = 7'd1; beat = 16'hFFFF; end
        4: begin bars = 7'($urandom_range(64, 1)); beat = 16'($urandom_range(6, 0));
                 send_gaps = 1'b0; end
        5: begin bars = 7'd65; beat = 16'd2; end
        default: begin bars = 7'($urandom); beat = 16'($urandom_range(9, 0)); end
      endcase
      configure(bars, beat);
      repeat (80) random_item();
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  // receiver holds off while ticks keep coming, then the sender waits for a full drain
  task automatic test_backpressure();
    configure(7'd3, 16'd1);
    if (!run_st) send_op(bpcs_pkg::OP_TOGGLE);
    hold_req = 1'b1;
    send_gaps = 1'b0;
    repeat (24) send_op(bpcs_pkg::OP_TICK);
    send_gaps = 1'b1;
    settle_idle();
    repeat (10) random_item();
  endtask

  // result receiver: random stall before each beat, or one long hold on request
  initial begin : result_sink
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      n = recv_gaps ? $urandom_range(17, 0) : 0;
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin : result_compare
    bpcs_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (exp_events.size() == 0) begin
        $error("unexpected event kind %0d bar %0d note %0d", event_kind_o, bar_position_o,
               note_position_o);
        errors++;
      end else begin
        want = exp_events.pop_front();
        if (event_kind_o !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, event_kind_o);
          errors++;
        end
        if (bar_position_o !== want.bar) begin
          $error("bar_position: expected %0d, got %0d", want.bar, bar_position_o);
          errors++;
        end
        if (note_position_o !== want.note) begin
          $error("note_position: expected %0d, got %0d", want.note, note_position_o);
          errors++;
        end
        if (running_o !== want.running) begin
          $error("running: expected %0d, got %0d", want.running, running_o);
          errors++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          errors++;
        end
        n_checked++;
        kinds_seen[event_kind_o]++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    bar_pos  = '0;
    note_pos = '0;
    beat_pos = '0;
    note_cd  = '0;
    beat_cd  = '0;
    run_st   = 1'b0;
    bar_cnt  = 7'd1;
    beat_iv  = 16'd500;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_init();
    test_directed();
    test_random_phases();
    test_backpressure();
    settle_idle();
    $display("sent %0d items over 9 register settings, checked %0d events", n_items, n_checked);
    $display("events: %0d clicks, %0d accents, %0d pattern clicks, %0d run changes",
             kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
